// File: rtl/core/pecp_pkg.sv
// shared types and codes of the pinned entry cache policy
package pecp_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam int PIN_BITS_DEF    = 16;
  localparam int CAP_BITS        = 5;
  localparam int STATUS_BITS     = 4;
  localparam int MODE_BITS       = 2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PIN    = 2'd0,
    MODE_UNPIN  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_WRITE  = 2'd3
  } pecp_mode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_NEW          = 4'd0,
    ST_REPIN_PINNED = 4'd1,
    ST_REPIN_FREE   = 4'd2,
    ST_REPLACED     = 4'd3,
    ST_FULL         = 4'd4,
    ST_SKIPPED      = 4'd5,
    ST_DECREMENTED  = 4'd6,
    ST_RELEASED     = 4'd7,
    ST_UNPIN_MISS   = 4'd8,
    ST_ACCESS_OK    = 4'd9,
    ST_ACCESS_MISS  = 4'd10
  } pecp_status_e;

  // per-cell shift control of the order list
  typedef struct packed {
    logic load;
    logic take_right;
    logic take_left;
  } pecp_cell_ctl_t;

endpackage

// File: rtl/core/pecp_order_cell.sv
// one cell of the order list: holds a slot number, loads a new one or shifts from either neighbor
module pecp_order_cell
  import pecp_pkg::*;
#(
  parameter int SLOT_BITS = 4
) (
  input  logic                 clk_i,
  input  pecp_cell_ctl_t       ctl_i,
  input  logic [SLOT_BITS-1:0] load_i,
  input  logic [SLOT_BITS-1:0] left_i,
  input  logic [SLOT_BITS-1:0] right_i,
  output logic [SLOT_BITS-1:0] slot_o
);

  logic [SLOT_BITS-1:0] slot_q;

  always_ff @(posedge clk_i) begin
    priority if (ctl_i.load) begin
      slot_q <= load_i;
    end else if (ctl_i.take_right) begin
      slot_q <= right_i;
    end else if (ctl_i.take_left) begin
      slot_q <= left_i;
    end else begin
      slot_q <= slot_q;
    end
  end

  assign slot_o = slot_q;

endmodule

// File: rtl/core/pinned_entry_cache_policy.sv
// top level of the pinned entry cache policy: slot table, order list, control
//
// usage
// - input channel: in_valid_i with mode/key/batch_last; a beat is taken when
//   in_valid_i is high and in_stall_o is low
// - output channel: one result beat per input beat, out_valid_o with the
//   result fields; the receiver holds it with out_stall_i
// - config channel: cfg_valid_i/cfg_ready_o writes the capacity register;
//   ready is always high, write only while the block is idle
// - result path: key compare over all slots, then update of tables, order
//   list and output register; one item at a time, the next input beat is
//   taken only after the update of the last one is done
// - the order list is a row of cells; a move to front or rear is one
//   parallel shift of the cells between the moved slot and that end
// - reset clears pin counts, dirty marks, entry count, skip flag, output valid
//   and sets capacity to 16; key storage and order cells hold garbage until
//   written, only slots in use are ever read
// - when the receiver stalls, a finished item waits in the update stage
//   until the output register frees up; the next input is held off meanwhile
module pinned_entry_cache_policy
  import pecp_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int PIN_BITS    = PIN_BITS_DEF,
  localparam int SLOT_BITS  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CAP_BITS-1:0]    cfg_data_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [MODE_BITS-1:0]   mode_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic                   batch_last_i,
  // results
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_BITS-1:0] status_o,
  output logic [SLOT_BITS-1:0]   slot_o,
  output logic [PIN_BITS-1:0]    pin_count_o,
  output logic                   evicted_valid_o,
  output logic [KEY_BITS-1:0]    evicted_key_o,
  output logic                   writeback_o
);

  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int CW       = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [1:0] MV_NONE   = 2'd0;
  localparam logic [1:0] MV_REAR   = 2'd1;
  localparam logic [1:0] MV_FRONT  = 2'd2;
  localparam logic [1:0] MV_APPEND = 2'd3;

  // control state
  logic [1:0]          state_q, state_d;
  logic [CAP_BITS-1:0] capacity_q;
  logic [CNT_BITS-1:0] used_q, used_d;
  logic                skip_q, skip_d;

  // captured item
  logic [MODE_BITS-1:0] mode_q;
  logic [KEY_BITS-1:0]  key_q;
  logic                 last_q;
  logic                 hit_q;
  logic [SLOT_BITS-1:0] hit_slot_q;

  // slot table
  logic [KEY_BITS-1:0] key_store_q [MAX_ENTRIES];
  logic [PIN_BITS-1:0] pin_store_q [MAX_ENTRIES];
  logic                dirty_q     [MAX_ENTRIES];

  // order list cells
  logic [SLOT_BITS-1:0] order_slot [MAX_ENTRIES];
  pecp_cell_ctl_t       cell_ctl   [MAX_ENTRIES];

  // output register
  logic                   out_valid_q;
  logic [STATUS_BITS-1:0] status_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [PIN_BITS-1:0]    pin_count_q;
  logic                   ev_valid_q;
  logic [KEY_BITS-1:0]    ev_key_q;
  logic                   wb_q;

  logic in_fire, exec_go;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign exec_go     = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_FIND;
      S_FIND:  state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      capacity_q <= CAP_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      last_q <= batch_last_i;
    end
  end

  // key compare against every slot in use; keys in use are unique
  logic                 match_any;
  logic [SLOT_BITS-1:0] match_slot;

  always_comb begin
    match_any  = 1'b0;
    match_slot = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (CNT_BITS'(j) < used_q && key_store_q[j] == key_q) begin
        match_any  = 1'b1;
        match_slot = match_slot | SLOT_BITS'(j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIND) begin
      hit_q      <= match_any;
      hit_slot_q <= match_slot;
    end
  end

  // effective capacity: zero acts as one, clipped to the table size
  logic [CW-1:0] cap_ext, cap_eff;
  logic          table_full;

  always_comb begin
    cap_ext = CW'(capacity_q);
    cap_eff = cap_ext;
    if (cap_ext == '0) cap_eff = CW'(1);
    if (cap_ext > CW'(MAX_ENTRIES)) cap_eff = CW'(MAX_ENTRIES);
  end

  assign table_full = (CW'(used_q) >= cap_eff);

  logic [PIN_BITS-1:0] hit_pin;
  logic                hit_dirty;
  logic [SLOT_BITS-1:0] front_slot;
  logic [PIN_BITS-1:0]  front_pin;

  assign hit_pin    = pin_store_q[hit_slot_q];
  assign hit_dirty  = dirty_q[hit_slot_q];
  assign front_slot = order_slot[0];
  assign front_pin  = pin_store_q[front_slot];

  // update decision
  logic                   pin_we, dirty_we, dirty_val, key_we;
  logic [SLOT_BITS-1:0]   wr_slot;
  logic [PIN_BITS-1:0]    pin_val;
  logic [1:0]             move;
  pecp_status_e           res_status;
  logic [SLOT_BITS-1:0]   res_slot;
  logic [PIN_BITS-1:0]    res_pin;
  logic                   res_ev;
  logic [KEY_BITS-1:0]    res_ev_key;
  logic                   res_wb;

  always_comb begin
    skip_d     = skip_q;
    used_d     = used_q;
    pin_we     = 1'b0;
    dirty_we   = 1'b0;
    dirty_val  = 1'b0;
    key_we     = 1'b0;
    wr_slot    = hit_slot_q;
    pin_val    = '0;
    move       = MV_NONE;
    res_status = ST_NEW;
    res_slot   = '0;
    res_pin    = '0;
    res_ev     = 1'b0;
    res_ev_key = '0;
    res_wb     = 1'b0;
    if (mode_q == MODE_PIN) begin
      priority if (skip_q) begin
        res_status = ST_SKIPPED;
        if (last_q) skip_d = 1'b0;
      end else if (hit_q) begin
        res_status = (hit_pin != '0) ? ST_REPIN_PINNED : ST_REPIN_FREE;
        pin_we     = 1'b1;
        pin_val    = (hit_pin == '1) ? hit_pin : hit_pin + PIN_BITS'(1);
        move       = MV_REAR;
        res_slot   = hit_slot_q;
        res_pin    = pin_val;
      end else if (table_full) begin
        if (front_pin != '0) begin
          res_status = ST_FULL;
          if (!last_q) skip_d = 1'b1;
        end else begin
          // replace the unpinned entry at the front
          res_status = ST_REPLACED;
          res_ev     = 1'b1;
          res_ev_key = key_store_q[front_slot];
          wr_slot    = front_slot;
          key_we     = 1'b1;
          pin_we     = 1'b1;
          pin_val    = PIN_BITS'(1);
          dirty_we   = 1'b1;
          move       = MV_REAR;
          res_slot   = front_slot;
          res_pin    = PIN_BITS'(1);
        end
      end else begin
        // fresh slot, taken in order
        res_status = ST_NEW;
        wr_slot    = used_q[SLOT_BITS-1:0];
        key_we     = 1'b1;
        pin_we     = 1'b1;
        pin_val    = PIN_BITS'(1);
        dirty_we   = 1'b1;
        move       = MV_APPEND;
        used_d     = used_q + CNT_BITS'(1);
        res_slot   = wr_slot;
        res_pin    = PIN_BITS'(1);
      end
    end else begin
      skip_d = 1'b0;
      if (mode_q == MODE_UNPIN) begin
        if (hit_q && hit_pin != '0) begin
          pin_we   = 1'b1;
          pin_val  = hit_pin - PIN_BITS'(1);
          res_slot = hit_slot_q;
          res_pin  = pin_val;
          if (pin_val == '0) begin
            move       = MV_FRONT;
            res_wb     = hit_dirty;
            dirty_we   = 1'b1;
            res_status = ST_RELEASED;
          end else begin
            res_status = ST_DECREMENTED;
          end
        end else begin
          res_status = ST_UNPIN_MISS;
        end
      end else begin
        if (hit_q && hit_pin != '0) begin
          dirty_we   = 1'b1;
          dirty_val  = (mode_q == MODE_WRITE);
          res_status = ST_ACCESS_OK;
          res_slot   = hit_slot_q;
          res_pin    = hit_pin;
        end else begin
          res_status = ST_ACCESS_MISS;
        end
      end
    end
  end

  // position of the moved slot in the order list
  logic [CNT_BITS-1:0] pos;
  logic                pos_found;

  always_comb begin
    pos       = '0;
    pos_found = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!pos_found && CNT_BITS'(i) < used_q && order_slot[i] == wr_slot) begin
        pos       = CNT_BITS'(i);
        pos_found = 1'b1;
      end
    end
  end

  // shift control for each cell
  logic [CNT_BITS-1:0] used_last;
  assign used_last = used_q - CNT_BITS'(1);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cell_ctl[i] = '0;
      if (exec_go) begin
        unique case (move)
          MV_REAR: begin
            if (CNT_BITS'(i) == used_last) begin
              cell_ctl[i].load = 1'b1;
            end else if (CNT_BITS'(i) >= pos && CNT_BITS'(i) < used_last) begin
              cell_ctl[i].take_right = 1'b1;
            end
          end
          MV_FRONT: begin
            if (i == 0) begin
              cell_ctl[i].load = 1'b1;
            end else if (CNT_BITS'(i) <= pos) begin
              cell_ctl[i].take_left = 1'b1;
            end
          end
          MV_APPEND: begin
            if (CNT_BITS'(i) == used_q) cell_ctl[i].load = 1'b1;
          end
          default: cell_ctl[i] = '0;
        endcase
      end
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cells
    logic [SLOT_BITS-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = order_slot[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = order_slot[g+1];
    end
    pecp_order_cell #(
      .SLOT_BITS(SLOT_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl[g]),
      .load_i (wr_slot),
      .left_i (left_v),
      .right_i(right_v),
      .slot_o (order_slot[g])
    );
  end

  // slot table updates
  always_ff @(posedge clk_i) begin
    if (exec_go && key_we) begin
      key_store_q[wr_slot] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        pin_store_q[j] <= '0;
        dirty_q[j]     <= 1'b0;
      end
      used_q <= '0;
      skip_q <= 1'b0;
    end else if (exec_go) begin
      if (pin_we)   pin_store_q[wr_slot] <= pin_val;
      if (dirty_we) dirty_q[wr_slot]     <= dirty_val;
      used_q <= used_d;
      skip_q <= skip_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      status_q    <= res_status;
      slot_q      <= res_slot;
      pin_count_q <= res_pin;
      ev_valid_q  <= res_ev;
      ev_key_q    <= res_ev_key;
      wb_q        <= res_wb;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign pin_count_o     = pin_count_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_key_o   = ev_key_q;
  assign writeback_o     = wb_q;

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_BITS'(MAX_ENTRIES) >= used_q)
    else $error("entry count above table size");

  a_find_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIND |=> state_q == S_EXEC)
    else $error("compare stage not followed by update");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (used_q == $past(used_q) || used_q == $past(used_q) + CNT_BITS'(1)))
    else $error("entry count jumped");

  a_evict_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_REPLACED |-> evicted_valid_o)
    else $error("replacement without eviction flag");

endmodule
